/* rtl/core/bracketing_secant_root_step_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the bracketing secant root step block
// Concurrent checks that are compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef BRACKETING_SECANT_ROOT_STEP_DEFINES_SVH
`define BRACKETING_SECANT_ROOT_STEP_DEFINES_SVH
`ifndef SYNTHESIS
`define BSRS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bsrs: property failed");
`define BSRS_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("bsrs: forbidden condition seen");
`else
`define BSRS_ASSERT(lbl, clk, rst_n, prop)
`define BSRS_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* rtl/core/bsrs_pkg.sv */
// ----------------------------------------------------------------------------
// bsrs_pkg
// Types, widths and codes shared by the secant root step modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsrs_pkg;

  localparam int DATA_W     = 32;
  localparam int WIDE_W     = 44;
  localparam int OPND_W     = DATA_W + 1;
  localparam int PROD_W     = 2 * OPND_W;
  localparam int REM_W      = OPND_W + 1;
  localparam int RADIX_BITS = 2;
  localparam int DIV_STEPS  = PROD_W / RADIX_BITS;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int BW_W       = 31;
  localparam int STEP_SHIFT = 40;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [OPND_W-1:0] opnd_t;

  localparam wide_t SAT_MAX  = (wide_t'(1) <<< (DATA_W - 1)) - wide_t'(1);
  localparam wide_t SAT_MIN  = -SAT_MAX - wide_t'(1);
  localparam wide_t BW_MAX   = (wide_t'(1) <<< BW_W) - wide_t'(1);
  localparam wide_t STEP_LIM = wide_t'(1) <<< STEP_SHIFT;
  localparam opnd_t DIV_TEN  = opnd_t'(10);

  typedef enum logic [1:0] {
    PH_STARTUP = 2'd0,
    PH_HUNT    = 2'd1,
    PH_BRACKET = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    STS_FOUND   = 2'd0,
    STS_BRACKET = 2'd1,
    STS_HUNT    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    IVL_EXACT = 2'd0,
    IVL_NONE  = 2'd1,
    IVL_WIDTH = 2'd2
  } ivl_t;

  typedef enum logic [3:0] {
    OP_FIRST,
    OP_FOUND,
    OP_ZERO,
    OP_OPEN,
    OP_HUNT_EQ,
    OP_HUNT,
    OP_OUTSIDE,
    OP_LOW_EQ,
    OP_LOW,
    OP_HIGH_EQ,
    OP_HIGH
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } fsm_t;

  typedef struct packed {
    logic load;
    logic decide;
    logic mul;
    logic div;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

/* rtl/core/bsrs_ctrl.sv */
// ----------------------------------------------------------------------------
// bsrs_ctrl
// Sequencer: accept, decode, multiply and divide (only when a quotient is needed), commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bracketing_secant_root_step_defines.svh"

module bsrs_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output bsrs_pkg::ctrl_cmd_t      cmd,
  input  wire bsrs_pkg::dp_sts_t   sts
);
  import bsrs_pkg::*;

  fsm_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    cmd      = '0;
    in_stall = 1'b1;
    unique case (st_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          st_nxt   = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        st_nxt     = sts.need_div ? ST_MUL : ST_FIN;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        st_nxt  = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_last) st_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          st_nxt     = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  `BSRS_ASSERT(a_load_decode, clk, rst_n, (st_r == ST_IDLE && in_valid) |=> st_r == ST_DECIDE)
  `BSRS_ASSERT(a_div_runs, clk, rst_n, (st_r == ST_DIV && !sts.div_last) |=> st_r == ST_DIV)
  `BSRS_ASSERT(a_fin_waits, clk, rst_n, (st_r == ST_FIN && !sts.out_free) |=> st_r == ST_FIN)

endmodule

`default_nettype wire

/* rtl/core/bsrs_dp.sv */
// ----------------------------------------------------------------------------
// bsrs_dp
// Search state, operand selection, multiplier, radix-4 divider, result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bracketing_secant_root_step_defines.svh"

module bsrs_dp (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire bsrs_pkg::ctrl_cmd_t      cmd,
  output bsrs_pkg::dp_sts_t             sts,
  input  wire logic                     in_kind,
  input  wire bsrs_pkg::data_t          in_guess_x,
  input  wire bsrs_pkg::data_t          in_func_y,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output bsrs_pkg::data_t               out_next_x,
  output logic [1:0]                    out_status,
  output logic [1:0]                    out_interval_kind,
  output logic [bsrs_pkg::BW_W-1:0]     out_bracket_width
);
  import bsrs_pkg::*;

  function automatic data_t sat_data(input wide_t v);
    if (v > SAT_MAX) return data_t'(SAT_MAX);
    if (v < SAT_MIN) return data_t'(SAT_MIN);
    return data_t'(v);
  endfunction

  function automatic wide_t half_trunc(input wide_t v);
    if (v < 0) return -((-v) >>> 1);
    return v >>> 1;
  endfunction

  // transaction and search state
  logic   kind_r;
  data_t  x_r, y_r;
  data_t  low_x_r, low_y_r, high_x_r, high_y_r, prev_x_r, prev_y_r, root_x_r;
  data_t  low_x_nxt, low_y_nxt, high_x_nxt, high_y_nxt, prev_x_nxt, prev_y_nxt;
  data_t  root_x_nxt;
  phase_t phase_r, phase_nxt;
  logic   found_r, found_nxt, exact_r, exact_nxt, rising_r, rising_nxt;

  op_t    op_r, op_c;
  opnd_t  a_r, b_r, c_r, a_c, b_c, c_c;

  logic [PROD_W-1:0] dvd_r;
  logic [OPND_W-1:0] den_r;
  logic [REM_W-1:0]  rem_r;
  logic              neg_r, dz_r;
  logic [CNT_W-1:0]  cnt_r;

  logic              out_valid_r;
  data_t             out_next_x_r;
  status_t           out_status_r;
  ivl_t              out_ivl_r;
  logic [BW_W-1:0]   out_bw_r;

  wide_t xw, yw, lxw, lyw, hxw, hyw, pxw, pyw;
  wide_t ob_lx, ob_ly, ob_hx, ob_hy;
  logic  sign_chg, outside, uselow, open_lo;

  assign xw  = wide_t'(x_r);
  assign yw  = wide_t'(y_r);
  assign lxw = wide_t'(low_x_r);
  assign lyw = wide_t'(low_y_r);
  assign hxw = wide_t'(high_x_r);
  assign hyw = wide_t'(high_y_r);
  assign pxw = wide_t'(prev_x_r);
  assign pyw = wide_t'(prev_y_r);

  assign sign_chg = (yw < 0 && pyw > 0) || (yw > 0 && pyw < 0);
  assign outside  = (xw < lxw) || (xw > hxw);
  assign uselow   = rising_r ? (hyw > -lyw) : (lyw < -hyw);
  assign open_lo  = xw < pxw;
  assign ob_lx    = open_lo ? xw  : pxw;
  assign ob_hx    = open_lo ? pxw : xw;
  assign ob_ly    = open_lo ? yw  : pyw;
  assign ob_hy    = open_lo ? pyw : yw;

  // decode
  always_comb begin
    priority if (!kind_r)                op_c = OP_FIRST;
    else if (found_r)                    op_c = OP_FOUND;
    else if (y_r == '0)                  op_c = OP_ZERO;
    else if (phase_r == PH_BRACKET) begin
      priority if (outside)              op_c = OP_OUTSIDE;
      else if (uselow)                   op_c = (y_r == low_y_r) ? OP_LOW_EQ : OP_LOW;
      else                               op_c = (y_r == high_y_r) ? OP_HIGH_EQ : OP_HIGH;
    end
    else if (sign_chg)                   op_c = OP_OPEN;
    else if (y_r == prev_y_r)            op_c = OP_HUNT_EQ;
    else                                 op_c = OP_HUNT;
  end

  always_comb begin
    a_c = '0;
    b_c = '0;
    c_c = '0;
    unique case (op_c)
      OP_OPEN: begin
        a_c = opnd_t'(ob_ly);
        b_c = opnd_t'(ob_hx - ob_lx);
        c_c = opnd_t'(ob_hy - ob_ly);
      end
      OP_HUNT: begin
        a_c = opnd_t'(yw);
        b_c = opnd_t'(xw - pxw);
        c_c = opnd_t'(yw - pyw);
      end
      OP_LOW_EQ: begin
        a_c = opnd_t'(hxw - lxw);
        b_c = opnd_t'(1);
        c_c = DIV_TEN;
      end
      OP_HIGH_EQ: begin
        a_c = opnd_t'(lxw - xw);
        b_c = opnd_t'(1);
        c_c = DIV_TEN;
      end
      OP_LOW: begin
        a_c = opnd_t'(-yw);
        b_c = opnd_t'(xw - lxw);
        c_c = opnd_t'(yw - lyw);
      end
      OP_HIGH: begin
        a_c = opnd_t'(-yw);
        b_c = opnd_t'(hxw - xw);
        c_c = opnd_t'(hyw - yw);
      end
      default: begin
        a_c = '0;
        b_c = '0;
        c_c = '0;
      end
    endcase
  end

  assign sts.need_div = (op_c == OP_OPEN) || (op_c == OP_HUNT) || (op_c == OP_LOW_EQ) ||
                        (op_c == OP_HIGH_EQ) || (op_c == OP_LOW) || (op_c == OP_HIGH);
  assign sts.div_last = cnt_r == CNT_W'(DIV_STEPS - 1);
  assign sts.out_free = !out_valid_r || !out_stall;

  // multiplier and divider
  logic signed [PROD_W-1:0] prod_s;
  logic [PROD_W-1:0]        dvd_step;
  logic [REM_W-1:0]         rem_step;

  assign prod_s = a_r * b_r;

  always_comb begin
    rem_step = rem_r;
    dvd_step = dvd_r;
    for (int i = 0; i < RADIX_BITS; i++) begin
      rem_step = {rem_step[REM_W-2:0], dvd_step[PROD_W-1]};
      dvd_step = {dvd_step[PROD_W-2:0], 1'b0};
      if (rem_step >= {1'b0, den_r}) begin
        rem_step    = rem_step - {1'b0, den_r};
        dvd_step[0] = 1'b1;
      end
    end
  end

  logic [PROD_W-1:0] q_mag;
  wide_t             q_w;

  assign q_mag = dz_r ? '0 :
                 (dvd_r > PROD_W'($unsigned(STEP_LIM))) ? PROD_W'($unsigned(STEP_LIM)) : dvd_r;
  assign q_w   = neg_r ? -wide_t'(q_mag[WIDE_W-1:0]) : wide_t'(q_mag[WIDE_W-1:0]);

  // bracketed step
  wide_t br_d, br_xr, br_h, pick_x, nx_w;
  logic  br_found, br_root_is_x;

  always_comb begin
    if (rising_r) begin
      if (yw > 0) pick_x = (yw > -lyw) ? lxw : xw;
      else        pick_x = (-yw > hyw) ? hxw : xw;
    end else begin
      if (yw > 0) pick_x = (yw > -hyw) ? hxw : xw;
      else        pick_x = (-yw > lyw) ? lxw : xw;
    end
  end

  always_comb begin
    br_d         = q_w;
    br_h         = '0;
    br_found     = 1'b0;
    br_root_is_x = 1'b0;
    if (op_r == OP_LOW_EQ) begin
      br_d = (xw - lxw) <<< 1;
      if (br_d < q_w) br_d = q_w;
    end else if (op_r == OP_HIGH_EQ) begin
      br_d = (xw - hxw) <<< 1;
      if (br_d > q_w) br_d = q_w;
    end
    br_xr = xw + br_d;
    if (br_d > 0) begin
      if (br_xr > hxw) begin
        br_h = (hxw - xw) >>> 1;
        if (br_h == 0) br_h = wide_t'(1);
        br_xr = xw + br_h;
      end
      br_found = br_xr >= hxw;
    end else if (br_d < 0) begin
      if (br_xr < lxw) begin
        br_h = -((xw - lxw) >>> 1);
        if (br_h == 0) br_h = -wide_t'(1);
        br_xr = xw + br_h;
      end
      br_found = br_xr <= lxw;
    end else begin
      br_found     = 1'b1;
      br_root_is_x = 1'b1;
    end
  end

  // commit values
  always_comb begin
    low_x_nxt  = low_x_r;
    low_y_nxt  = low_y_r;
    high_x_nxt = high_x_r;
    high_y_nxt = high_y_r;
    prev_x_nxt = prev_x_r;
    prev_y_nxt = prev_y_r;
    root_x_nxt = root_x_r;
    phase_nxt  = phase_r;
    found_nxt  = found_r;
    exact_nxt  = exact_r;
    rising_nxt = rising_r;
    nx_w       = xw;
    unique case (op_r)
      OP_FIRST: begin
        prev_x_nxt = x_r;
        prev_y_nxt = y_r;
        phase_nxt  = PH_STARTUP;
        found_nxt  = (y_r == '0);
        exact_nxt  = (y_r == '0);
        if (y_r == '0) root_x_nxt = x_r;
      end
      OP_FOUND: nx_w = wide_t'(root_x_r);
      OP_ZERO: begin
        root_x_nxt = x_r;
        found_nxt  = 1'b1;
        exact_nxt  = 1'b1;
      end
      OP_OPEN: begin
        phase_nxt  = PH_BRACKET;
        low_x_nxt  = data_t'(ob_lx);
        high_x_nxt = data_t'(ob_hx);
        low_y_nxt  = data_t'(ob_ly);
        high_y_nxt = data_t'(ob_hy);
        rising_nxt = ob_ly < ob_hy;
        nx_w       = ob_lx - q_w;
      end
      OP_HUNT_EQ: begin
        phase_nxt  = PH_HUNT;
        prev_x_nxt = x_r;
        prev_y_nxt = y_r;
      end
      OP_HUNT: begin
        phase_nxt  = PH_HUNT;
        prev_x_nxt = x_r;
        prev_y_nxt = y_r;
        nx_w       = xw - half_trunc(q_w + (q_w <<< 1));
      end
      OP_OUTSIDE: nx_w = half_trunc(lxw + hxw);
      OP_LOW_EQ, OP_LOW, OP_HIGH_EQ, OP_HIGH: begin
        nx_w = br_xr;
        if (br_found) begin
          found_nxt  = 1'b1;
          root_x_nxt = br_root_is_x ? x_r : data_t'(pick_x);
          nx_w       = br_root_is_x ? xw : pick_x;
        end
        if ((rising_r && yw > 0) || (!rising_r && yw < 0)) begin
          high_x_nxt = x_r;
          high_y_nxt = y_r;
        end else begin
          low_x_nxt = x_r;
          low_y_nxt = y_r;
        end
      end
      default: nx_w = xw;
    endcase
  end

  status_t st_c;
  ivl_t    ik_c;
  wide_t   w_c;
  logic [BW_W-1:0] bw_c;

  always_comb begin
    st_c = found_nxt ? STS_FOUND : ((phase_nxt == PH_HUNT) ? STS_HUNT : STS_BRACKET);
    w_c  = wide_t'(high_x_nxt) - wide_t'(low_x_nxt);
    bw_c = '0;
    if (exact_nxt) begin
      ik_c = IVL_EXACT;
    end else if (phase_nxt == PH_HUNT) begin
      ik_c = IVL_NONE;
    end else begin
      ik_c = IVL_WIDTH;
      priority if (w_c < 0)     bw_c = '0;
      else if (w_c > BW_MAX)    bw_c = BW_MAX[BW_W-1:0];
      else                      bw_c = w_c[BW_W-1:0];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      x_r    <= in_guess_x;
      y_r    <= in_func_y;
    end
    if (cmd.decide) begin
      op_r <= op_c;
      a_r  <= a_c;
      b_r  <= b_c;
      c_r  <= c_c;
    end
    if (cmd.mul) begin
      dvd_r <= prod_s[PROD_W-1] ? PROD_W'(-prod_s) : PROD_W'(prod_s);
      den_r <= c_r[OPND_W-1] ? OPND_W'(-c_r) : OPND_W'(c_r);
      rem_r <= '0;
      neg_r <= prod_s[PROD_W-1] ^ c_r[OPND_W-1];
      dz_r  <= (c_r == '0);
      cnt_r <= '0;
    end else if (cmd.div) begin
      dvd_r <= dvd_step;
      rem_r <= rem_step;
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (cmd.commit) begin
      out_next_x_r <= sat_data(nx_w);
      out_status_r <= st_c;
      out_ivl_r    <= ik_c;
      out_bw_r     <= bw_c;
    end
  end

  // search state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_x_r     <= '0;
      low_y_r     <= '0;
      high_x_r    <= '0;
      high_y_r    <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      root_x_r    <= '0;
      phase_r     <= PH_STARTUP;
      found_r     <= 1'b0;
      exact_r     <= 1'b0;
      rising_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        low_x_r  <= low_x_nxt;
        low_y_r  <= low_y_nxt;
        high_x_r <= high_x_nxt;
        high_y_r <= high_y_nxt;
        prev_x_r <= prev_x_nxt;
        prev_y_r <= prev_y_nxt;
        root_x_r <= root_x_nxt;
        phase_r  <= phase_nxt;
        found_r  <= found_nxt;
        exact_r  <= exact_nxt;
        rising_r <= rising_nxt;
      end
      out_valid_r <= cmd.commit || (out_valid_r && out_stall);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_next_x        = out_next_x_r;
  assign out_status        = out_status_r;
  assign out_interval_kind = out_ivl_r;
  assign out_bracket_width = out_bw_r;

  `BSRS_ASSERT(a_exact_found, clk, rst_n, (out_valid_r && out_ivl_r == IVL_EXACT) |-> out_status_r == STS_FOUND)
  `BSRS_NEVER(a_width_kind, clk, rst_n, out_valid_r && out_ivl_r != IVL_WIDTH && out_bw_r != '0)
  `BSRS_ASSERT(a_found_hold, clk, rst_n, (cmd.commit && op_r == OP_FOUND) |=> $stable(root_x_r))

endmodule

`default_nettype wire

/* rtl/core/bracketing_secant_root_step.sv */
// ----------------------------------------------------------------------------
// bracketing_secant_root_step
// One step of a safeguarded secant root search on signed Q16.16 values.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one guess and the function
//   value there; in_kind low restarts the search, high continues it.
//   Result channel (out_valid / out_stall) returns one transaction per input:
//   next guess (or root), status, interval kind and bracket width.
// Timing:
//   Steps needing a quotient (secant, hunt or tenth of the bracket) go from
//   acceptance through decode, one 33x33 multiply, the radix-4 divider steps
//   and commit; other steps go from decode to commit. One transaction is in
//   flight at a time; in_stall is high from acceptance until the result is
//   registered, so a new transaction is not taken before then.
//   The 66-by-33-bit divider sets the rate.
// Reset:
//   Synchronous, active low; clears the bracket, previous iterate, mode and
//   flags, and empties the output register.
// Stall:
//   A held result stays on the out_ ports; the next transaction may be taken
//   and computed meanwhile, and waits in its final cycle until the slot frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bracketing_secant_root_step (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_kind,
  input  wire bsrs_pkg::data_t           in_guess_x,
  input  wire bsrs_pkg::data_t           in_func_y,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output bsrs_pkg::data_t                out_next_x,
  output logic [1:0]                     out_status,
  output logic [1:0]                     out_interval_kind,
  output logic [bsrs_pkg::BW_W-1:0]      out_bracket_width
);
  import bsrs_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  bsrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  bsrs_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_kind           (in_kind),
    .in_guess_x        (in_guess_x),
    .in_func_y         (in_func_y),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_next_x        (out_next_x),
    .out_status        (out_status),
    .out_interval_kind (out_interval_kind),
    .out_bracket_width (out_bracket_width)
  );

endmodule

`default_nettype wire

/* bench/bracketing_secant_root_step_tb.sv */
// ----------------------------------------------------------------------------
// bracketing_secant_root_step_tb
// Drives guess/value pairs through the secant root step block: a directed
// table of first guesses, zero residuals, bracket openings, hunt steps and
// extremes, then random restarted searches on linear functions
// with noise. Each transaction is checked field by field against a local
// model of the bracket search, under several sender/receiver idling phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bracketing_secant_root_step_tb;
  import bsrs_pkg::*;

  localparam int CYCLE_LIMIT = 20000;
  localparam int N_RANDOM    = 950;
  localparam longint VMAX_L  = 64'sh7FFF_FFFF;
  localparam longint VMIN_L  = -64'sh8000_0000;
  localparam longint LIM_L   = 64'sh100_0000_0000;

  typedef struct {
    logic            kind;
    logic [31:0]     gx;
    logic [31:0]     fy;
    bit              known;
    logic [31:0]     ex_x;
    logic [1:0]      ex_st;
    logic [1:0]      ex_ik;
    logic [30:0]     ex_w;
  } row_t;

  typedef struct {
    logic [31:0] nx;
    logic [1:0]  st;
    logic [1:0]  ik;
    logic [30:0] w;
  } step_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = 1'b0;
  data_t       in_guess_x = '0;
  data_t       in_func_y = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  data_t       out_next_x;
  logic [1:0]  out_status;
  logic [1:0]  out_interval_kind;
  logic [BW_W-1:0] out_bracket_width;

  always #5 clk = ~clk;

  bracketing_secant_root_step dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_guess_x(in_guess_x), .in_func_y(in_func_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_next_x(out_next_x), .out_status(out_status),
    .out_interval_kind(out_interval_kind), .out_bracket_width(out_bracket_width)
  );

  // search state
  longint lo_x, lo_y, hi_x, hi_y, pv_x, pv_y, rt_x;
  phase_t mode;
  bit     found, exact, rising;

  step_res_t pending_q[$];
  row_t      table_q[$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        sending_done = 1'b0;

  function automatic longint sat32(longint v);
    if (v > VMAX_L) return VMAX_L;
    if (v < VMIN_L) return VMIN_L;
    return v;
  endfunction

  function automatic longint clamp_step(longint v);
    if (v > LIM_L) return LIM_L;
    if (v < -LIM_L) return -LIM_L;
    return v;
  endfunction

  function automatic longint scaled_quot(longint a, longint b, longint c);
    if (c == 0) return 0;
    return (a * b) / c;
  endfunction

  function automatic longint final_root(longint x, longint y);
    if (rising) begin
      if (y > 0) return (y > -lo_y) ? lo_x : x;
      return (-y > hi_y) ? hi_x : x;
    end
    if (y > 0) return (y > -hi_y) ? hi_x : x;
    return (-y > lo_y) ? lo_x : x;
  endfunction

  function automatic longint open_interval(longint x, longint y);
    mode = PH_BRACKET;
    if (x < pv_x) begin
      lo_x = x; hi_x = pv_x; lo_y = y; hi_y = pv_y;
    end else begin
      lo_x = pv_x; hi_x = x; lo_y = pv_y; hi_y = y;
    end
    rising = lo_y < hi_y;
    return sat32(lo_x - scaled_quot(lo_y, hi_x - lo_x, hi_y - lo_y));
  endfunction

  function automatic longint secant_step(longint x, longint y);
    longint d, lim, xr;
    bit from_low;
    if (x < lo_x || x > hi_x) return sat32((lo_x + hi_x) / 2);
    from_low = rising ? (hi_y > -lo_y) : (lo_y < -hi_y);
    if (from_low) begin
      if (y == lo_y) begin
        d = 2 * (x - lo_x);
        lim = (hi_x - lo_x) / 10;
        if (d < lim) d = lim;
      end else d = scaled_quot(-y, x - lo_x, y - lo_y);
    end else begin
      if (y == hi_y) begin
        d = 2 * (x - hi_x);
        lim = (lo_x - x) / 10;
        if (d > lim) d = lim;
      end else d = scaled_quot(-y, hi_x - x, hi_y - y);
    end
    d = clamp_step(d);
    xr = x + d;
    if (d > 0) begin
      if (xr > hi_x) begin
        d = (hi_x - x) / 2;
        if (d == 0) d = 1;
        xr = x + d;
      end
      if (xr >= hi_x) begin
        found = 1; rt_x = final_root(x, y); xr = rt_x;
      end
    end else if (d < 0) begin
      if (xr < lo_x) begin
        d = (lo_x - x) / 2;
        if (d == 0) d = -1;
        xr = x + d;
      end
      if (xr <= lo_x) begin
        found = 1; rt_x = final_root(x, y); xr = rt_x;
      end
    end else begin
      rt_x = x; found = 1; xr = x;
    end
    if ((rising && y > 0) || (!rising && y < 0)) begin
      hi_x = x; hi_y = y;
    end else begin
      lo_x = x; lo_y = y;
    end
    return sat32(xr);
  endfunction

  function automatic longint hunt(longint x, longint y);
    longint q, xr;
    if ((y < 0 && pv_y > 0) || (y > 0 && pv_y < 0)) return open_interval(x, y);
    if (y == pv_y) xr = x;
    else begin
      q = clamp_step(scaled_quot(y, x - pv_x, y - pv_y));
      xr = sat32(x - (3 * q) / 2);
    end
    pv_x = x; pv_y = y;
    return xr;
  endfunction

  function automatic step_res_t predict_step(logic kind, logic [31:0] gx,
                                             logic [31:0] fy);
    longint x, y, nx, w;
    step_res_t r;
    x = longint'(signed'(gx));
    y = longint'(signed'(fy));
    w = 0;
    if (!kind) begin
      pv_x = x; pv_y = y; mode = PH_STARTUP;
      found = (y == 0); exact = (y == 0);
      if (y == 0) rt_x = x;
      nx = x;
    end else if (found) nx = rt_x;
    else if (y == 0) begin
      rt_x = x; found = 1; exact = 1; nx = x;
    end else if (mode == PH_STARTUP) begin
      if ((y < 0 && pv_y > 0) || (y > 0 && pv_y < 0)) nx = open_interval(x, y);
      else begin
        mode = PH_HUNT;
        nx = hunt(x, y);
      end
    end else if (mode == PH_BRACKET) nx = secant_step(x, y);
    else nx = hunt(x, y);
    r.st = found ? STS_FOUND : (mode == PH_HUNT ? STS_HUNT : STS_BRACKET);
    if (exact) r.ik = IVL_EXACT;
    else if (mode == PH_HUNT) r.ik = IVL_NONE;
    else begin
      r.ik = IVL_WIDTH;
      w = hi_x - lo_x;
      if (w < 0) w = 0;
      if (w > 64'sh7FFF_FFFF) w = 64'sh7FFF_FFFF;
    end
    r.nx = nx[31:0];
    r.w = w[30:0];
    return r;
  endfunction

  task automatic add_row(logic kind, logic [31:0] gx, logic [31:0] fy);
    row_t r;
    r = '{kind, gx, fy, 1'b0, '0, '0, '0, '0};
    table_q.push_back(r);
  endtask

  task automatic add_known(logic kind, logic [31:0] gx, logic [31:0] fy,
                           logic [31:0] ex, logic [1:0] st, logic [1:0] ik,
                           logic [30:0] w);
    row_t r;
    r = '{kind, gx, fy, 1'b1, ex, st, ik, w};
    table_q.push_back(r);
  endtask

  task automatic send(logic kind, logic [31:0] gx, logic [31:0] fy);
    while (!sending_done && send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_guess_x <= gx;
    in_func_y <= fy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_q.push_back(predict_step(kind, gx, fy));
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction x=%h", out_next_x);
        end else begin
          step_res_t e;
          e = pending_q.pop_front();
          if (e.nx !== out_next_x || e.st !== out_status ||
              e.ik !== out_interval_kind || e.w !== out_bracket_width) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp x=%h st=%0d ik=%0d w=%h got x=%h st=%0d ik=%0d w=%h",
                       e.nx, e.st, e.ik, e.w, out_next_x, out_status,
                       out_interval_kind, out_bracket_width);
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= CYCLE_LIMIT) begin
        $display("bracketing_secant_root_step_tb: done, errors");
        $finish;
      end
      out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h4_0000) - 32'h2_0000;
      default: return $urandom;
    endcase
  endfunction

  // one restarted search on f(x) = a*(x - r) (+ small noise sometimes), random start
  task automatic run_search(output int n);
    longint r, a, x, y, nxt;
    int steps;
    r = longint'(signed'($urandom_range(0, 32'h100_0000) - 32'h80_0000));
    a = longint'($urandom_range(1, 32'h4_0000)) * ($urandom_range(1) ? 1 : -1);
    x = longint'(signed'($urandom));
    steps = $urandom_range(3, 12);
    n = 0;
    for (int i = 0; i < steps; i++) begin
      y = (a * (x - r)) >>> 16;
      if ($urandom_range(9) == 0) y += $urandom_range(0, 255) - 128;
      y = sat32(y);
      send(i != 0, x[31:0], y[31:0]);
      n++;
      nxt = longint'(signed'(pending_q.size() ? pending_q[$].nx : x[31:0]));
      x = ($urandom_range(7) == 0) ? longint'(signed'($urandom)) : nxt;
    end
  endtask

  initial begin
    int sent, n;
    int pcts_s[4];
    int pcts_r[4];
    pcts_s = '{0, 63, 0, 9};
    pcts_r = '{0, 0, 63, 9};
    lo_x = 0; lo_y = 0; hi_x = 0; hi_y = 0; pv_x = 0; pv_y = 0; rt_x = 0;
    mode = PH_STARTUP; found = 0; exact = 0; rising = 0;

    // next guess straight from reset, zero residual, restarts, extremes
    add_known(1'b1, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000, STS_FOUND, IVL_EXACT, '0);
    add_known(1'b1, 32'h1234_5678, 32'h0000_1000, 32'h0001_0000, STS_FOUND, IVL_EXACT, '0);
    add_known(1'b0, 32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, STS_FOUND, IVL_EXACT, '0);
    add_known(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, STS_BRACKET, IVL_WIDTH, '0);
    add_row(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_row(1'b1, 32'h0000_0000, 32'h4000_0000);
    add_row(1'b1, 32'h0000_0000, 32'h4000_0000);
    add_row(1'b1, 32'hFFFF_0000, 32'h3000_0000);
    add_row(1'b1, 32'h0010_0000, 32'hF000_0000);
    add_row(1'b1, 32'h0100_0000, 32'h0000_0100);
    add_row(1'b1, 32'h0000_8000, 32'h0100_0000);
    add_row(1'b1, 32'h0000_8000, 32'h0100_0000);
    add_row(1'b1, 32'h0000_9000, 32'hFF00_0000);
    add_row(1'b0, 32'h0000_0000, 32'hFFFF_0000);
    add_row(1'b1, 32'h0002_0000, 32'h0001_0000);
    add_row(1'b1, 32'h0001_0000, 32'hFFFF_0000);
    add_row(1'b1, 32'h0001_8000, 32'hFFFF_0000);
    add_row(1'b1, 32'h0001_C000, 32'h0000_4000);
    add_row(1'b1, 32'h0001_C001, 32'h0000_0001);
    add_row(1'b0, 32'h8000_0000, 32'h0000_0001);
    add_row(1'b1, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    add_row(1'b1, 32'h0000_0000, 32'h7FFF_FFFF);
    add_row(1'b0, 32'h0000_0000, 32'h0000_0001);
    add_row(1'b1, 32'h0000_0001, 32'h0000_0002);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (table_q[i]) begin
      send(table_q[i].kind, table_q[i].gx, table_q[i].fy);
      if (table_q[i].known &&
          (pending_q[$].nx !== table_q[i].ex_x || pending_q[$].st !== table_q[i].ex_st ||
           pending_q[$].ik !== table_q[i].ex_ik || pending_q[$].w !== table_q[i].ex_w)) begin
        mismatches++;
        if (mismatches <= 10) $display("directed row %0d: table and model disagree", i);
      end
    end

    sent = 0;
    for (int ph = 0; ph < 5; ph++) begin
      send_idle_pct <= (ph < 4) ? pcts_s[ph] : 0;
      recv_stall_pct <= (ph < 4) ? pcts_r[ph] : 0;
      while (sent < (N_RANDOM * (ph + 1)) / 5) begin
        if ($urandom_range(9) < 8) begin
          run_search(n);
          sent += n;
        end else begin
          send($urandom_range(1), rnd_word(), rnd_word());
          sent++;
        end
      end
    end
    sending_done = 1'b1;
    in_valid <= 1'b0;
    send_idle_pct <= 0;
    recv_stall_pct <= 0;

    n = 0;
    while (pending_q.size() != 0 && n < CYCLE_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0)
      $display("bracketing_secant_root_step_tb: done, clean");
    else
      $display("bracketing_secant_root_step_tb: done, errors");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/bsrs_pkg.sv
rtl/core/bsrs_ctrl.sv
rtl/core/bsrs_dp.sv
rtl/core/bracketing_secant_root_step.sv
bench/bracketing_secant_root_step_tb.sv
